>>> sv/uv_sphere_mesh_generator_defines.svh
// assertion macros of the sphere mesh generator, used by the back end module
`ifndef UV_SPHERE_MESH_GENERATOR_DEFINES_SVH
`define UV_SPHERE_MESH_GENERATOR_DEFINES_SVH

// same-cycle implication, checked on clk_i, off during reset
`define USMG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("usmg assertion failed");

// next-cycle implication, checked on clk_i, off during reset
`define USMG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("usmg assertion failed");

`endif

>>> sv/usmg_pkg.sv
// types, constants and tables of the uv sphere mesh generator
package usmg_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 1024;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  localparam int unsigned SEG_W = 11;
  localparam int unsigned TEX_W = 17;
  localparam int unsigned IDX_W = 21;
  localparam int unsigned Q_BITS = 17;
  localparam int unsigned REM_W = 12;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SEG_W-1:0] COLS_RESET = 11'd32;
  localparam logic [SEG_W-1:0] ROWS_RESET = 11'd16;

  localparam logic signed [33:0] CORDIC_ONE_K = 34'sh026DD3B6A;

  typedef enum logic {
    CMD_VERTEX = 1'b0,
    CMD_CELL   = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMN_SEGMENTS = 2'd0,
    CFG_ROW_SEGMENTS    = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [SEG_W-1:0] col;
    logic [SEG_W-1:0] row;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [TEX_W-1:0]   tex_u;
    logic [TEX_W-1:0]   tex_v;
    logic [IDX_W-1:0]   vertex_index;
    logic               last;
    logic               out_of_range;
  } out_t;

  // item data that rides along the arithmetic stages
  typedef struct packed {
    cmd_e             cmd;
    logic             oor;
    logic [SEG_W-1:0] col;
    logic [SEG_W-1:0] row;
    logic [SEG_W-1:0] xs;
    logic [SEG_W-1:0] ys;
  } side_t;

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;  1:  r = 32'h12E4051E;  2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;  4:  r = 32'h028B0D43;  5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;  7:  r = 32'h00517C55;  8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;  10: r = 32'h000A2F98;  11: r = 32'h000517CC;
      12: r = 32'h00028BE6;  13: r = 32'h000145F3;  14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;  16: r = 32'h000028BE;  17: r = 32'h0000145F;
      18: r = 32'h00000A30;  19: r = 32'h00000518;  20: r = 32'h0000028C;
      21: r = 32'h00000146;  22: r = 32'h000000A3;  23: r = 32'h00000051;
      24: r = 32'h00000029;  25: r = 32'h00000014;  26: r = 32'h0000000A;
      27: r = 32'h00000005;  28: r = 32'h00000003;  29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

>>> sv/usmg_div.sv
// front stage and bit-per-stage dividers for the texture coordinates
module usmg_div #(
  parameter int unsigned MAX_SEGMENTS = usmg_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  usmg_pkg::in_t               in_i,
  input  logic [usmg_pkg::SEG_W-1:0]  cols_i,
  input  logic [usmg_pkg::SEG_W-1:0]  rows_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output usmg_pkg::side_t             out_side_o,
  output logic [usmg_pkg::TEX_W-1:0]  out_u_o,
  output logic [usmg_pkg::TEX_W-1:0]  out_v_o
);

  localparam int unsigned NS = usmg_pkg::Q_BITS;
  localparam int unsigned RW = usmg_pkg::REM_W;
  localparam int unsigned SW = usmg_pkg::SEG_W;
  localparam int unsigned QW = usmg_pkg::Q_BITS;

  logic            v_q   [NS+1];
  usmg_pkg::side_t side_q[NS+1];
  logic [RW-1:0]   ru_q  [NS+1];
  logic [RW-1:0]   rv_q  [NS+1];
  logic [QW-1:0]   qu_q  [NS+1];
  logic [QW-1:0]   qv_q  [NS+1];

  logic            rdy   [NS+2];
  logic [RW-1:0]   ru_d  [NS+1];
  logic [RW-1:0]   rv_d  [NS+1];
  logic [QW-1:0]   qu_d  [NS+1];
  logic [QW-1:0]   qv_d  [NS+1];

  usmg_pkg::side_t side_d;
  logic [SW-1:0]   xs_eff;
  logic [SW-1:0]   ys_eff;

  function automatic logic [SW-1:0] eff_seg(input logic [SW-1:0] r);
    logic [SW-1:0] e;
    if (r == '0) begin
      e = SW'(1);
    end else if (17'(r) > 17'(MAX_SEGMENTS)) begin
      e = SW'(MAX_SEGMENTS);
    end else begin
      e = r;
    end
    return e;
  endfunction

  // low numerator bits are the divisor half added for rounding
  function automatic logic num_bit(input logic [SW-1:0] s, input int unsigned b);
    logic [QW-1:0] t;
    t = QW'(s);
    return t[b];
  endfunction

  function automatic logic [RW:0] div_step(input logic [RW-1:0] r,
                                           input logic [SW-1:0] s,
                                           input logic nb);
    logic [RW:0] t;
    logic [RW:0] d;
    logic [RW:0] res;
    t = {r, nb};
    d = {1'b0, s, 1'b0};
    if (t >= d) begin
      res = {1'b1, RW'(t - d)};
    end else begin
      res = {1'b0, t[RW-1:0]};
    end
    return res;
  endfunction

  always_comb begin
    xs_eff = eff_seg(cols_i);
    ys_eff = eff_seg(rows_i);
    side_d.cmd = in_i.cmd;
    side_d.col = in_i.col;
    side_d.row = in_i.row;
    side_d.xs  = xs_eff;
    side_d.ys  = ys_eff;
    if (in_i.cmd == usmg_pkg::CMD_VERTEX) begin
      side_d.oor = (in_i.col > xs_eff) || (in_i.row > ys_eff);
    end else begin
      side_d.oor = (in_i.col >= xs_eff) || (in_i.row >= ys_eff);
    end
  end

  always_comb begin
    logic [RW:0] su;
    logic [RW:0] sv;
    rdy[NS+1] = out_ready_i;
    for (int k = NS; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    ru_d[0] = '0;
    rv_d[0] = '0;
    qu_d[0] = '0;
    qv_d[0] = '0;
    for (int k = 1; k <= NS; k++) begin
      su = div_step(ru_q[k-1], side_q[k-1].xs, num_bit(side_q[k-1].xs, NS - k));
      sv = div_step(rv_q[k-1], side_q[k-1].ys, num_bit(side_q[k-1].ys, NS - k));
      ru_d[k] = su[RW-1:0];
      rv_d[k] = sv[RW-1:0];
      qu_d[k] = qu_q[k-1];
      qv_d[k] = qv_q[k-1];
      qu_d[k][NS-k] = su[RW];
      qv_d[k][NS-k] = sv[RW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy[0]) begin
      side_q[0] <= side_d;
      ru_q[0]   <= RW'(in_i.col);
      rv_q[0]   <= RW'(in_i.row);
      qu_q[0]   <= '0;
      qv_q[0]   <= '0;
    end
    for (int k = 1; k <= NS; k++) begin
      if (v_q[k-1] && rdy[k]) begin
        side_q[k] <= side_q[k-1];
        ru_q[k]   <= ru_d[k];
        rv_q[k]   <= rv_d[k];
        qu_q[k]   <= qu_d[k];
        qv_q[k]   <= qv_d[k];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS];
  assign out_side_o  = side_q[NS];
  assign out_u_o     = qu_q[NS];
  assign out_v_o     = qv_q[NS];

endmodule

>>> sv/usmg_cordic.sv
// pipelined rotation cordic for cosine and sine of both angles
module usmg_cordic #(
  parameter int unsigned CORDIC_STEPS = usmg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  usmg_pkg::side_t             in_side_i,
  input  logic [usmg_pkg::TEX_W-1:0]  in_u_i,
  input  logic [usmg_pkg::TEX_W-1:0]  in_v_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output usmg_pkg::side_t             out_side_o,
  output logic [usmg_pkg::TEX_W-1:0]  out_u_o,
  output logic [usmg_pkg::TEX_W-1:0]  out_v_o,
  output logic signed [31:0]          out_ct_o,
  output logic signed [31:0]          out_st_o,
  output logic signed [31:0]          out_cp_o,
  output logic signed [31:0]          out_sp_o
);

  localparam int unsigned NS = CORDIC_STEPS;
  localparam int unsigned TW = usmg_pkg::TEX_W;

  logic               v_q   [NS+2];
  usmg_pkg::side_t    side_q[NS+2];
  logic [TW-1:0]      u_q   [NS+2];
  logic [TW-1:0]      tv_q  [NS+2];
  logic [1:0]         qt_q  [NS+2];
  logic [1:0]         qp_q  [NS+2];
  logic signed [33:0] xt_q  [NS+1];
  logic signed [33:0] yt_q  [NS+1];
  logic signed [32:0] zt_q  [NS+1];
  logic signed [33:0] xp_q  [NS+1];
  logic signed [33:0] yp_q  [NS+1];
  logic signed [32:0] zp_q  [NS+1];
  logic signed [31:0] ct_q, st_q, cp_q, sp_q;

  logic               rdy   [NS+3];
  logic signed [33:0] xt_d  [NS+1];
  logic signed [33:0] yt_d  [NS+1];
  logic signed [32:0] zt_d  [NS+1];
  logic signed [33:0] xp_d  [NS+1];
  logic signed [33:0] yp_d  [NS+1];
  logic signed [32:0] zp_d  [NS+1];

  logic [31:0]        theta;
  logic [31:0]        phi;
  logic signed [31:0] ct_d, st_d, cp_d, sp_d;

  // one micro-rotation: {x, y, z} of the next step
  function automatic logic [100:0] rot(input logic signed [33:0] x,
                                       input logic signed [33:0] y,
                                       input logic signed [32:0] z,
                                       input int unsigned i);
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [32:0] a;
    logic signed [33:0] nx;
    logic signed [33:0] ny;
    logic signed [32:0] nz;
    dx = y >>> i;
    dy = x >>> i;
    a  = $signed({1'b0, usmg_pkg::atan_turn(i)});
    if (z >= 0) begin
      nx = x - dx;
      ny = y + dy;
      nz = z - a;
    end else begin
      nx = x + dx;
      ny = y - dy;
      nz = z + a;
    end
    return {nx, ny, nz};
  endfunction

  // quadrant fold: {cos, sin}
  function automatic logic [63:0] fold(input logic [1:0] q,
                                       input logic signed [33:0] x,
                                       input logic signed [33:0] y);
    logic signed [33:0] c;
    logic signed [33:0] s;
    case (q)
      2'd0: begin
        c = x;
        s = y;
      end
      2'd1: begin
        c = -y;
        s = x;
      end
      2'd2: begin
        c = -x;
        s = -y;
      end
      default: begin
        c = y;
        s = -x;
      end
    endcase
    return {32'(c), 32'(s)};
  endfunction

  assign theta = {in_u_i[15:0], 16'b0};
  assign phi   = {in_v_i, 15'b0};

  always_comb begin
    rdy[NS+2] = out_ready_i;
    for (int k = NS + 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    xt_d[0] = '0;
    yt_d[0] = '0;
    zt_d[0] = '0;
    xp_d[0] = '0;
    yp_d[0] = '0;
    zp_d[0] = '0;
    for (int k = 1; k <= NS; k++) begin
      {xt_d[k], yt_d[k], zt_d[k]} = rot(xt_q[k-1], yt_q[k-1], zt_q[k-1], k - 1);
      {xp_d[k], yp_d[k], zp_d[k]} = rot(xp_q[k-1], yp_q[k-1], zp_q[k-1], k - 1);
    end
    {ct_d, st_d} = fold(qt_q[NS], xt_q[NS], yt_q[NS]);
    {cp_d, sp_d} = fold(qp_q[NS], xp_q[NS], yp_q[NS]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS + 1; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k <= NS + 1; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy[0]) begin
      side_q[0] <= in_side_i;
      u_q[0]    <= in_u_i;
      tv_q[0]   <= in_v_i;
      qt_q[0]   <= theta[31:30];
      qp_q[0]   <= phi[31:30];
      xt_q[0]   <= usmg_pkg::CORDIC_ONE_K;
      yt_q[0]   <= '0;
      zt_q[0]   <= $signed({3'b0, theta[29:0]});
      xp_q[0]   <= usmg_pkg::CORDIC_ONE_K;
      yp_q[0]   <= '0;
      zp_q[0]   <= $signed({3'b0, phi[29:0]});
    end
    for (int k = 1; k <= NS + 1; k++) begin
      if (v_q[k-1] && rdy[k]) begin
        side_q[k] <= side_q[k-1];
        u_q[k]    <= u_q[k-1];
        tv_q[k]   <= tv_q[k-1];
        qt_q[k]   <= qt_q[k-1];
        qp_q[k]   <= qp_q[k-1];
      end
    end
    for (int k = 1; k <= NS; k++) begin
      if (v_q[k-1] && rdy[k]) begin
        xt_q[k] <= xt_d[k];
        yt_q[k] <= yt_d[k];
        zt_q[k] <= zt_d[k];
        xp_q[k] <= xp_d[k];
        yp_q[k] <= yp_d[k];
        zp_q[k] <= zp_d[k];
      end
    end
    if (v_q[NS] && rdy[NS+1]) begin
      ct_q <= ct_d;
      st_q <= st_d;
      cp_q <= cp_d;
      sp_q <= sp_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS+1];
  assign out_side_o  = side_q[NS+1];
  assign out_u_o     = u_q[NS+1];
  assign out_v_o     = tv_q[NS+1];
  assign out_ct_o    = ct_q;
  assign out_st_o    = st_q;
  assign out_cp_o    = cp_q;
  assign out_sp_o    = sp_q;

endmodule

>>> sv/usmg_back.sv
// products, rounding and the result register that expands cells into six beats
`include "uv_sphere_mesh_generator_defines.svh"
module usmg_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  usmg_pkg::side_t             in_side_i,
  input  logic [usmg_pkg::TEX_W-1:0]  in_u_i,
  input  logic [usmg_pkg::TEX_W-1:0]  in_v_i,
  input  logic signed [31:0]          in_ct_i,
  input  logic signed [31:0]          in_st_i,
  input  logic signed [31:0]          in_cp_i,
  input  logic signed [31:0]          in_sp_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output usmg_pkg::out_t              out_o
);

  localparam int unsigned IW = usmg_pkg::IDX_W;
  localparam int unsigned TW = usmg_pkg::TEX_W;
  localparam logic [2:0] LAST_BEAT = 3'd5;

  // product stage
  logic               m_v_q;
  usmg_pkg::side_t    m_side_q;
  logic [TW-1:0]      m_u_q, m_v2_q;
  logic signed [63:0] m_px_q, m_pz_q;
  logic signed [31:0] m_cp_q;
  logic [IW-1:0]      m_b_q;
  logic [IW-1:0]      m_xs1_q;

  // rounding stage
  logic               r_v_q;
  logic               r_cell_q;
  usmg_pkg::out_t     r_out_q;
  logic [IW-1:0]      r_a_q, r_b_q;

  // result register
  logic               e_v_q;
  logic               e_cell_q;
  logic [2:0]         e_cnt_q;
  usmg_pkg::out_t     e_out_q;
  logic [IW-1:0]      e_a_q, e_b_q;

  logic               e_ready, r_ready, m_ready, e_final;
  usmg_pkg::out_t     r_out_d;
  logic               r_cell_d;
  logic [11:0]        xs1;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -64'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign e_final = !e_cell_q || (e_cnt_q == LAST_BEAT);
  assign e_ready = !e_v_q || (out_ready_i && e_final);
  assign r_ready = !r_v_q || e_ready;
  assign m_ready = !m_v_q || r_ready;
  assign in_ready_o = m_ready;
  assign xs1 = {1'b0, in_side_i.xs} + 12'd1;

  always_comb begin
    logic signed [63:0] hx;
    logic signed [63:0] hz;
    logic signed [63:0] hy;
    hx = (m_px_q + (64'sd1 <<< 44)) >>> 45;
    hz = (m_pz_q + (64'sd1 <<< 44)) >>> 45;
    hy = (64'(m_cp_q) + 64'sd16384) >>> 15;
    r_out_d = '0;
    r_out_d.last = 1'b1;
    r_cell_d = 1'b0;
    if (m_side_q.oor) begin
      r_out_d.out_of_range = 1'b1;
    end else if (m_side_q.cmd == usmg_pkg::CMD_VERTEX) begin
      r_out_d.pos_x = sat16(hx);
      r_out_d.pos_y = sat16(hy);
      r_out_d.pos_z = sat16(hz);
      r_out_d.tex_u = m_u_q;
      r_out_d.tex_v = m_v2_q;
    end else begin
      r_cell_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q   <= 1'b0;
      r_v_q   <= 1'b0;
      e_v_q   <= 1'b0;
      e_cnt_q <= '0;
    end else begin
      if (m_ready) begin
        m_v_q <= in_valid_i;
      end
      if (r_ready) begin
        r_v_q <= m_v_q;
      end
      if (e_ready) begin
        e_v_q   <= r_v_q;
        e_cnt_q <= '0;
      end else if (out_ready_i) begin
        e_cnt_q <= e_cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && m_ready) begin
      m_side_q <= in_side_i;
      m_u_q    <= in_u_i;
      m_v2_q   <= in_v_i;
      m_px_q   <= in_ct_i * in_sp_i;
      m_pz_q   <= in_st_i * in_sp_i;
      m_cp_q   <= in_cp_i;
      m_b_q    <= IW'(in_side_i.row * xs1 + 23'(in_side_i.col));
      m_xs1_q  <= IW'(xs1);
    end
    if (m_v_q && r_ready) begin
      r_out_q  <= r_out_d;
      r_cell_q <= r_cell_d;
      r_b_q    <= m_b_q;
      r_a_q    <= m_b_q + m_xs1_q;
    end
    if (r_v_q && e_ready) begin
      e_out_q  <= r_out_q;
      e_cell_q <= r_cell_q;
      e_a_q    <= r_a_q;
      e_b_q    <= r_b_q;
    end
  end

  // corners a, b, b+1, a, b+1, a+1
  always_comb begin
    out_o = e_out_q;
    if (e_cell_q) begin
      out_o = '0;
      out_o.last = (e_cnt_q == LAST_BEAT);
      case (e_cnt_q)
        3'd0, 3'd3: out_o.vertex_index = e_a_q;
        3'd1:       out_o.vertex_index = e_b_q;
        3'd2, 3'd4: out_o.vertex_index = e_b_q + IW'(1);
        3'd5:       out_o.vertex_index = e_a_q + IW'(1);
        default:    out_o.vertex_index = e_a_q;
      endcase
    end
  end

  assign out_valid_o = e_v_q;

  `USMG_ASSERT_NOW(a_cnt_bound, e_v_q && e_cell_q, e_cnt_q <= LAST_BEAT)
  `USMG_ASSERT_NEXT(a_cnt_step, e_v_q && !e_final && out_ready_i,
                    e_v_q && e_cell_q && (e_cnt_q == $past(e_cnt_q) + 3'd1))
  `USMG_ASSERT_NOW(a_err_single, e_v_q && e_out_q.out_of_range, !e_cell_q && out_o.last)
  `USMG_ASSERT_NEXT(a_round_hold, r_v_q && !e_ready, r_v_q && $stable(r_out_q))

endmodule

>>> sv/uv_sphere_mesh_generator.sv
// top level of the uv sphere mesh generator: config registers and pipeline
//
//  channel  | beat                        | handshake
//  ---------+-----------------------------+---------------------------
//  in       | in_i  (cmd, col, row)       | in_valid_i / in_stall_o
//  out      | out_o (pos, tex, idx, flags)| out_valid_o / out_stall_i
//  cfg      | cfg_idx_i, cfg_data_i       | cfg_we_i, no wait
//
// one item enters per cycle while in_stall_o is low; items pass the divider, cordic and back end
// a vertex or an off-grid item gives one beat, a cell gives six beats in a row,
// so a cell holds the pipeline at the result register until its last beat is taken
// every stage has its own valid; bubbles close up while the output is stalled
// reset clears valids and loads 32 columns and 16 rows
module uv_sphere_mesh_generator #(
  parameter int unsigned MAX_SEGMENTS = usmg_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned CORDIC_STEPS = usmg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  usmg_pkg::in_t                   in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output usmg_pkg::out_t                  out_o,
  input  logic                            cfg_we_i,
  input  logic [usmg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [usmg_pkg::SEG_W-1:0]      cfg_data_i
);

  logic [usmg_pkg::SEG_W-1:0] cols_q, rows_q;

  logic                       in_ready;
  logic                       d_valid, d_ready;
  usmg_pkg::side_t            d_side;
  logic [usmg_pkg::TEX_W-1:0] d_u, d_v;
  logic                       c_valid, c_ready;
  usmg_pkg::side_t            c_side;
  logic [usmg_pkg::TEX_W-1:0] c_u, c_v;
  logic signed [31:0]         c_ct, c_st, c_cp, c_sp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= usmg_pkg::COLS_RESET;
      rows_q <= usmg_pkg::ROWS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        usmg_pkg::CFG_COLUMN_SEGMENTS: cols_q <= cfg_data_i;
        usmg_pkg::CFG_ROW_SEGMENTS:    rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  usmg_div #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .in_i        (in_i),
    .cols_i      (cols_q),
    .rows_i      (rows_q),
    .out_valid_o (d_valid),
    .out_ready_i (d_ready),
    .out_side_o  (d_side),
    .out_u_o     (d_u),
    .out_v_o     (d_v)
  );

  usmg_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d_valid),
    .in_ready_o  (d_ready),
    .in_side_i   (d_side),
    .in_u_i      (d_u),
    .in_v_i      (d_v),
    .out_valid_o (c_valid),
    .out_ready_i (c_ready),
    .out_side_o  (c_side),
    .out_u_o     (c_u),
    .out_v_o     (c_v),
    .out_ct_o    (c_ct),
    .out_st_o    (c_st),
    .out_cp_o    (c_cp),
    .out_sp_o    (c_sp)
  );

  usmg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (c_valid),
    .in_ready_o  (c_ready),
    .in_side_i   (c_side),
    .in_u_i      (c_u),
    .in_v_i      (c_v),
    .in_ct_i     (c_ct),
    .in_st_i     (c_st),
    .in_cp_i     (c_cp),
    .in_sp_i     (c_sp),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .out_o       (out_o)
  );

  assign in_stall_o = !in_ready;

endmodule

>>> test/tb_top.sv
// testbench of the uv sphere mesh generator: directed table, random vertices and cells
`timescale 1ns / 1ps

module tb_top;
  import usmg_pkg::*;

  localparam int unsigned LATENCY = CORDIC_STEPS_DEF + 23;
  localparam int unsigned N_RANDOM = 200;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t in_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [SEG_W-1:0] cfg_data_i;

  uv_sphere_mesh_generator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_o(out_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // register copies held by the predictor
  logic [SEG_W-1:0] cols_reg;
  logic [SEG_W-1:0] rows_reg;

  out_t beat_queue[$];
  int unsigned n_errors;
  longint unsigned n_cycles;
  bit hold_off;
  bit holding;

  // directed rows: expected beat filled in only for the easy cases
  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } dir_row_t;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("uv_sphere_mesh_generator regression: fail");
      $finish;
    end
  end

  function automatic logic [SEG_W-1:0] seg_used(input logic [SEG_W-1:0] r);
    if (r == 0) return SEG_W'(1);
    if (r > MAX_SEGMENTS_DEF) return SEG_W'(MAX_SEGMENTS_DEF);
    return r;
  endfunction

  function automatic longint floor_sh(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  task automatic cordic_turns(input logic [31:0] ang, output longint c, output longint s);
    longint x, y, z, nx, dx, dy;
    logic [1:0] quad;
    quad = ang[31:30];
    z = longint'(ang[29:0]);
    x = longint'(CORDIC_ONE_K);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (z >= 0) begin
        nx = x - dx; y = y + dy; z = z - longint'(atan_turn(i));
      end else begin
        nx = x + dx; y = y - dy; z = z + longint'(atan_turn(i));
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic predict_mesh_beats(input in_t it);
    longint unsigned xs, ys, u, v, a, b;
    longint ct, st, cp, sp;
    longint unsigned corner[6];
    out_t o;
    xs = seg_used(cols_reg);
    ys = seg_used(rows_reg);
    o = '0;
    if (it.cmd == CMD_VERTEX) begin
      if (it.col > xs || it.row > ys) begin
        o.last = 1'b1; o.out_of_range = 1'b1;
      end else begin
        u = (it.col * 131072 + xs) / (2 * xs);
        v = (it.row * 131072 + ys) / (2 * ys);
        cordic_turns(32'(u << 16), ct, st);
        cordic_turns(32'(v << 15), cp, sp);
        o.pos_x = clamp16(floor_sh(ct * sp + (64'sd1 <<< 44), 45));
        o.pos_y = clamp16(floor_sh(cp + (64'sd1 <<< 14), 15));
        o.pos_z = clamp16(floor_sh(st * sp + (64'sd1 <<< 44), 45));
        o.tex_u = u[TEX_W-1:0];
        o.tex_v = v[TEX_W-1:0];
        o.last = 1'b1;
      end
      beat_queue = {beat_queue, o};
    end else if (it.col >= xs || it.row >= ys) begin
      o.last = 1'b1; o.out_of_range = 1'b1;
      beat_queue = {beat_queue, o};
    end else begin
      a = (it.row + 1) * (xs + 1) + it.col;
      b = it.row * (xs + 1) + it.col;
      corner = '{a, b, b + 1, a, b + 1, a + 1};
      for (int k = 0; k < 6; k++) begin
        o = '0;
        o.vertex_index = corner[k][IDX_W-1:0];
        o.last = (k == 5);
        beat_queue = {beat_queue, o};
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, n_cycles);
  endtask

  // checker of result beats
  always @(posedge clk_i) begin
    out_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (beat_queue.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        w = beat_queue.pop_front();
        if (out_o.pos_x !== w.pos_x) report_mismatch("pos_x", out_o.pos_x, w.pos_x);
        if (out_o.pos_y !== w.pos_y) report_mismatch("pos_y", out_o.pos_y, w.pos_y);
        if (out_o.pos_z !== w.pos_z) report_mismatch("pos_z", out_o.pos_z, w.pos_z);
        if (out_o.tex_u !== w.tex_u) report_mismatch("tex_u", out_o.tex_u, w.tex_u);
        if (out_o.tex_v !== w.tex_v) report_mismatch("tex_v", out_o.tex_v, w.tex_v);
        if (out_o.vertex_index !== w.vertex_index)
          report_mismatch("vertex_index", out_o.vertex_index, w.vertex_index);
        if (out_o.last !== w.last) report_mismatch("last", out_o.last, w.last);
        if (out_o.out_of_range !== w.out_of_range)
          report_mismatch("out_of_range", out_o.out_of_range, w.out_of_range);
      end
    end
  end

  // receiver stalls: mostly short gaps, a few long, one long hold-off on request
  initial begin
    int unsigned n;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        holding = 1'b1;
        out_stall_i <= 1'b1;
        for (int i = 0; i < 300; i++) @(negedge clk_i);
        hold_off = 1'b0;
        holding = 1'b0;
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(10, 40)) @(negedge clk_i); // stretch with no stalls
      end
    end
  end

  // valid stays high between beats; it drops only for a gap or a pause
  task automatic send_item(input in_t it, input bit gaps);
    int unsigned g;
    if (gaps && $urandom_range(0, 3) == 0) begin
      g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_mesh_beats(it);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [SEG_W-1:0] val);
    in_valid_i <= 1'b0;
    while (beat_queue.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_COLUMN_SEGMENTS) cols_reg = val;
    else rows_reg = val;
  endtask

  function automatic in_t mk(input cmd_e c, input int unsigned co, input int unsigned ro);
    in_t t;
    t.cmd = c; t.col = co[SEG_W-1:0]; t.row = ro[SEG_W-1:0];
    return t;
  endfunction

  task automatic random_item(input bit gaps);
    in_t t;
    int unsigned xs, ys;
    xs = seg_used(cols_reg);
    ys = seg_used(rows_reg);
    t.cmd = cmd_e'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      t.col = SEG_W'($urandom); t.row = SEG_W'($urandom);
    end else begin
      t.col = SEG_W'($urandom_range(0, xs));
      t.row = SEG_W'($urandom_range(0, ys));
    end
    send_item(t, gaps);
  endtask

  initial begin
    dir_row_t dir_rows[13];
    out_t oor;
    logic [SEG_W-1:0] col_set[6];
    logic [SEG_W-1:0] row_set[6];
    in_valid_i = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_COLUMN_SEGMENTS;
    cfg_data_i = '0;
    n_errors = 0;
    n_cycles = 0;
    hold_off = 1'b0;
    holding = 1'b0;
    cols_reg = COLS_RESET;
    rows_reg = ROWS_RESET;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    oor = '0; oor.last = 1'b1; oor.out_of_range = 1'b1;
    dir_rows[0]  = '{mk(CMD_VERTEX, 0, 0), 0, '0};
    dir_rows[1]  = '{mk(CMD_VERTEX, 32, 16), 0, '0};
    dir_rows[2]  = '{mk(CMD_VERTEX, 8, 8), 0, '0};
    dir_rows[3]  = '{mk(CMD_VERTEX, 16, 4), 0, '0};
    dir_rows[4]  = '{mk(CMD_VERTEX, 24, 12), 0, '0};
    dir_rows[5]  = '{mk(CMD_VERTEX, 33, 0), 1, oor};
    dir_rows[6]  = '{mk(CMD_VERTEX, 0, 17), 1, oor};
    dir_rows[7]  = '{mk(CMD_VERTEX, 2047, 2047), 1, oor};
    dir_rows[8]  = '{mk(CMD_CELL, 0, 0), 0, '0};
    dir_rows[9]  = '{mk(CMD_CELL, 31, 15), 0, '0};
    dir_rows[10] = '{mk(CMD_CELL, 32, 0), 1, oor};
    dir_rows[11] = '{mk(CMD_CELL, 0, 16), 1, oor};
    dir_rows[12] = '{mk(CMD_CELL, 1365, 682), 1, oor};
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        // typed-in expectation stands in for the predictor
        in_i <= dir_rows[i].item;
        in_valid_i <= 1'b1;
        @(posedge clk_i);
        while (in_stall_o) @(posedge clk_i);
        beat_queue = {beat_queue, dir_rows[i].want};
        @(negedge clk_i);
      end else begin
        send_item(dir_rows[i].item, 1'b0);
      end
    end

    // register extremes: zero, one, max, above max; then other sizes
    col_set = '{11'd0, 11'd1024, 11'd2047, 11'd7, 11'd1, 11'd100};
    row_set = '{11'd0, 11'd1024, 11'd2047, 11'd1, 11'd9, 11'd50};
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_COLUMN_SEGMENTS, col_set[p]);
      write_reg(CFG_ROW_SEGMENTS, row_set[p]);
      if (p == 1) begin
        send_item(mk(CMD_VERTEX, 1024, 1024), 1'b0);
        send_item(mk(CMD_CELL, 1023, 1023), 1'b0);
        send_item(mk(CMD_VERTEX, 1025, 0), 1'b0);
      end
      if (p == 3) begin
        // back-to-back items against a long receiver hold-off
        hold_off = 1'b1;
        wait (holding);
        for (int i = 0; i < 60; i++) random_item(1'b0);
      end else begin
        for (int i = 0; i < N_RANDOM / 6; i++) random_item(1'b1);
      end
    end

    in_valid_i <= 1'b0;
    while (beat_queue.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 20) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("uv_sphere_mesh_generator regression: pass");
    end else begin
      $display("uv_sphere_mesh_generator regression: fail");
    end
    $finish;
  end

endmodule
